/* hdl/iset_pkg.sv */
package iset_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int COORD_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ROLE_MERGED  = 3'd0,
        ROLE_REMOVED = 3'd1,
        ROLE_CREATED = 3'd2,
        ROLE_FULL    = 3'd3,
        ROLE_NOP     = 3'd4
    } role_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FIND,
        ST_REMOVE,
        ST_STORE_M,
        ST_STORE_L,
        ST_STORE_R,
        ST_OUT
    } state_t;

endpackage

/* hdl/iset_if.sv */
interface iset_req_if
    import iset_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [COORD_WIDTH-1:0] lo;
    logic [COORD_WIDTH-1:0] hi;

    modport source (output valid, kind, lo, hi, input ready);
    modport sink   (input valid, kind, lo, hi, output ready);
endinterface

interface iset_rsp_if
    import iset_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             role;
    logic [COORD_WIDTH-1:0] seg_lo;
    logic [COORD_WIDTH-1:0] seg_hi;
    logic                   last;

    modport source (output valid, role, seg_lo, seg_hi, last, input ready);
    modport sink   (input valid, role, seg_lo, seg_hi, last, output ready);
endinterface

/* hdl/iset_ram.sv */
module iset_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/interval_set_merge_split_core.sv */
// Channel | Dir | Payload                         | Transfer
// req     | in  | kind, lo, hi                    | valid && ready
// rsp     | out | role, seg_lo, seg_hi, last      | valid && ready
//
// One item at a time. The table is scanned through the entry RAM read
// port; each removed entry costs another pass over the table (min search
// over selected slots), and each result waits in ST_OUT for rsp ready.
// Reset clears the valid bits and the count; no clearing pass.
// req stalls until the last result of the item has transferred.
module interval_set_merge_split_core
    import iset_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    iset_req_if.sink    req,
    iset_rsp_if.source  rsp
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CW     = COORD_WIDTH;

    state_t state_reg, state_next, ret_reg;

    logic                kind_reg;
    logic [CW-1:0]       lo_reg, hi_reg, min_lo_reg, max_hi_reg;
    logic [CAPACITY-1:0] valid_reg, sel_reg;
    logic [CNT_W-1:0]    count_reg, k_reg, cnt_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [CW-1:0]       best_lo_reg, best_hi_reg;
    role_t               role_reg;
    logic [CW-1:0]       seg_lo_reg, seg_hi_reg;
    logic                last_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr, ram_raddr, pidx, free_idx;
    logic [2*CW-1:0]     ram_wdata, ram_rdata;
    logic [CW-1:0]       e_lo, e_hi;
    logic [CNT_W-1:0]    pidx_full;
    logic                scan_end, proc, hit, has_left, has_right, overflow;
    logic [CNT_W:0]      after_cnt;
    logic [CAPACITY-1:0] sel_left, best_bit;

    iset_ram #(
        .WIDTH (2 * CW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign e_lo      = ram_rdata[2*CW-1:CW];
    assign e_hi      = ram_rdata[CW-1:0];
    assign scan_end  = (cnt_reg == CNT_W'(CAPACITY));
    assign proc      = (cnt_reg != '0);
    assign pidx_full = cnt_reg - CNT_W'(1);
    assign pidx      = pidx_full[IDX_W-1:0];
    assign ram_raddr = scan_end ? '0 : cnt_reg[IDX_W-1:0];

    assign hit = valid_reg[pidx] &&
                 (kind_reg ? (e_hi > lo_reg && e_lo < hi_reg)
                           : (e_hi >= lo_reg && e_lo <= hi_reg));

    assign has_left  = min_lo_reg < lo_reg;
    assign has_right = max_hi_reg > hi_reg;
    assign after_cnt = {1'b0, count_reg} - {1'b0, k_reg}
                     + (CNT_W+1)'(has_left) + (CNT_W+1)'(has_right);
    assign overflow  = after_cnt > (CNT_W+1)'(CAPACITY);

    assign best_bit = CAPACITY'(1) << best_idx_reg;
    assign sel_left = sel_reg & ~best_bit;

    always_comb
    begin
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = free_idx;
        ram_wdata = {min_lo_reg, max_hi_reg};
        case (state_reg)
            ST_STORE_M: ram_we = 1'b1;
            ST_STORE_L:
            begin
                ram_we    = 1'b1;
                ram_wdata = {min_lo_reg, lo_reg};
            end
            ST_STORE_R:
            begin
                ram_we    = 1'b1;
                ram_wdata = {hi_reg, max_hi_reg};
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.hi <= req.lo) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (k_reg == '0)
                begin
                    state_next = kind_reg ? ST_OUT
                               : (count_reg >= CNT_W'(CAPACITY)) ? ST_OUT : ST_STORE_M;
                end
                else
                begin
                    state_next = (kind_reg && overflow) ? ST_OUT : ST_FIND;
                end
            end
            ST_FIND:
            begin
                if (scan_end)
                begin
                    state_next = ST_REMOVE;
                end
            end
            ST_REMOVE:  state_next = ST_OUT;
            ST_STORE_M: state_next = ST_OUT;
            ST_STORE_L: state_next = ST_OUT;
            ST_STORE_R: state_next = ST_OUT;
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        rsp.valid = (state_reg == ST_OUT);
    end

    assign rsp.role   = role_reg;
    assign rsp.seg_lo = seg_lo_reg;
    assign rsp.seg_hi = seg_hi_reg;
    assign rsp.last   = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_REMOVE)
            begin
                valid_reg[best_idx_reg] <= 1'b0;
                count_reg               <= count_reg - CNT_W'(1);
            end
            else if (ram_we)
            begin
                valid_reg[free_idx] <= 1'b1;
                count_reg           <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                kind_reg   <= req.kind;
                lo_reg     <= req.lo;
                hi_reg     <= req.hi;
                min_lo_reg <= req.lo;
                max_hi_reg <= req.hi;
                k_reg      <= '0;
                sel_reg    <= '0;
                cnt_reg    <= '0;
                role_reg   <= ROLE_NOP;
                seg_lo_reg <= req.lo;
                seg_hi_reg <= req.hi;
                last_reg   <= 1'b1;
                ret_reg    <= ST_IDLE;
            end
            ST_SCAN:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (proc && hit)
                begin
                    sel_reg[pidx] <= 1'b1;
                    k_reg         <= k_reg + CNT_W'(1);
                    if (e_lo < min_lo_reg)
                    begin
                        min_lo_reg <= e_lo;
                    end
                    if (e_hi > max_hi_reg)
                    begin
                        max_hi_reg <= e_hi;
                    end
                end
            end
            ST_DECIDE:
            begin
                cnt_reg   <= '0;
                found_reg <= 1'b0;
                ret_reg   <= ST_IDLE;
                last_reg  <= 1'b1;
                if (kind_reg && k_reg == '0)
                begin
                    role_reg <= ROLE_NOP;
                end
                else
                begin
                    role_reg <= ROLE_FULL;
                end
            end
            ST_FIND:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (proc && sel_reg[pidx] && (!found_reg || e_lo < best_lo_reg))
                begin
                    found_reg    <= 1'b1;
                    best_idx_reg <= pidx;
                    best_lo_reg  <= e_lo;
                    best_hi_reg  <= e_hi;
                end
            end
            ST_REMOVE:
            begin
                sel_reg    <= sel_left;
                cnt_reg    <= '0;
                found_reg  <= 1'b0;
                role_reg   <= ROLE_REMOVED;
                seg_lo_reg <= best_lo_reg;
                seg_hi_reg <= best_hi_reg;
                last_reg   <= (sel_left == '0) && kind_reg && !has_left && !has_right;
                if (sel_left != '0)
                begin
                    ret_reg <= ST_FIND;
                end
                else if (!kind_reg)
                begin
                    ret_reg <= ST_STORE_M;
                end
                else if (has_left)
                begin
                    ret_reg <= ST_STORE_L;
                end
                else if (has_right)
                begin
                    ret_reg <= ST_STORE_R;
                end
                else
                begin
                    ret_reg <= ST_IDLE;
                end
            end
            ST_STORE_M:
            begin
                role_reg   <= ROLE_MERGED;
                seg_lo_reg <= min_lo_reg;
                seg_hi_reg <= max_hi_reg;
                last_reg   <= 1'b1;
                ret_reg    <= ST_IDLE;
            end
            ST_STORE_L:
            begin
                role_reg   <= ROLE_CREATED;
                seg_lo_reg <= min_lo_reg;
                seg_hi_reg <= lo_reg;
                last_reg   <= !has_right;
                ret_reg    <= has_right ? ST_STORE_R : ST_IDLE;
            end
            ST_STORE_R:
            begin
                role_reg   <= ROLE_CREATED;
                seg_lo_reg <= hi_reg;
                seg_hi_reg <= max_hi_reg;
                last_reg   <= 1'b1;
                ret_reg    <= ST_IDLE;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !valid_reg[free_idx])
        else $error("store into occupied slot");
`endif

endmodule
